### hw/rtl/bgpr_pkg.sv
`default_nettype none
package bgpr_pkg;
   localparam int NumTermsDefault = 6;
   localparam int NumLanes = 4;
   localparam int DivSteps = 64;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusLoaded = 2'd1;
   localparam logic [1:0] StatusUncal = 2'd2;
   localparam logic [1:0] StatusSat = 2'd3;

   localparam logic CmdLoad = 1'b0;
   localparam logic CmdCompute = 1'b1;

   localparam logic [7:0] IpdReset = 8'd64;
   localparam logic [11:0] PlaneReset = 12'd400;
   localparam logic [11:0] HeightReset = 12'd410;

   localparam logic [1:0] CsrIpd = 2'd0;
   localparam logic [1:0] CsrPlane = 2'd1;
   localparam logic [1:0] CsrHeight = 2'd2;
   localparam logic [1:0] CsrReady = 2'd3;

   localparam logic signed [31:0] QMax = 32'sh7fffffff;
   localparam logic signed [31:0] QMin = 32'sh80000000;

   function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
      if (v > 96'sd2147483647) begin
         return QMax;
      end else if (v < -96'sd2147483648) begin
         return QMin;
      end
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

### hw/rtl/binocular_gaze_point_of_regard_core.sv
// Binocular gaze point-of-regard core.
// Throughput: one item per cycle when the result side keeps up.
// Path from acceptance to result: the lane registers, the merge stage, the divider pipeline and the output register.
// The whole pipeline stalls when the output register holds an item not yet taken.
// Reset restores the register defaults; the coefficient table is undefined until loaded.
`default_nettype none
module binocular_gaze_point_of_regard_core
   import bgpr_pkg::*;
#(
   parameter int NUM_TERMS = NumTermsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic [4:0]         req_coeff_index,
   input  wire logic signed [31:0] req_coeff_value,
   input  wire logic [11:0]        req_right_pupil_x,
   input  wire logic [11:0]        req_right_pupil_y,
   input  wire logic [11:0]        req_left_pupil_x,
   input  wire logic [11:0]        req_left_pupil_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_gaze_x,
   output logic signed [31:0]      rsp_gaze_y,
   output logic signed [31:0]      rsp_gaze_z,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   localparam int Depth = 4 * NUM_TERMS;
   localparam int IdxW = $clog2(Depth);
   localparam int NW = 80;

   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       plane;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic       sat;
      logic signed [31:0] mq;
   } meta_type;

   logic [7:0] ipd_ff;
   logic [11:0] plane_ff, height_ff;
   logic ready_ff;
   logic signed [31:0] table_ff [Depth];
   logic signed [31:0] cf [4][NUM_TERMS];
   logic signed [31:0] fix [4];
   logic adv;
   logic out_valid_ff;
   logic [1:0] out_status_ff;
   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff;

   // The control pipe runs alongside the lanes.
   logic       c_valid_ff [3];
   logic [1:0] c_status_ff [3];

   assign adv = !out_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ipd_ff <= IpdReset;
         plane_ff <= PlaneReset;
         height_ff <= HeightReset;
         ready_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrIpd: ipd_ff <= csr_data[7:0];
            CsrPlane: plane_ff <= csr_data[11:0];
            CsrHeight: height_ff <= csr_data[11:0];
            CsrReady: ready_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && adv && req_command == CmdLoad
            && req_coeff_index < 5'(Depth)) begin
         table_ff[req_coeff_index[IdxW-1:0]] <= req_coeff_value;
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         for (int k = 0; k < NUM_TERMS; k++) begin
            cf[l][k] = table_ff[l * NUM_TERMS + k];
         end
      end
   end

   bgpr_lane #(.NUM_TERMS(NUM_TERMS)) u_rx (.clock, .enable(adv),
      .px(req_right_pupil_x), .py(req_right_pupil_y), .coeff(cf[0]), .fix(fix[0]));
   bgpr_lane #(.NUM_TERMS(NUM_TERMS)) u_ry (.clock, .enable(adv),
      .px(req_right_pupil_x), .py(req_right_pupil_y), .coeff(cf[1]), .fix(fix[1]));
   bgpr_lane #(.NUM_TERMS(NUM_TERMS)) u_lx (.clock, .enable(adv),
      .px(req_left_pupil_x), .py(req_left_pupil_y), .coeff(cf[2]), .fix(fix[2]));
   bgpr_lane #(.NUM_TERMS(NUM_TERMS)) u_ly (.clock, .enable(adv),
      .px(req_left_pupil_x), .py(req_left_pupil_y), .coeff(cf[3]), .fix(fix[3]));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            c_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         c_valid_ff[0] <= req_valid;
         for (int i = 1; i < 3; i++) begin
            c_valid_ff[i] <= c_valid_ff[i-1];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_status_ff[0] <= (req_command == CmdLoad) ? StatusLoaded
                         : (ready_ff ? StatusOk : StatusUncal);
         for (int i = 1; i < 3; i++) begin
            c_status_ff[i] <= c_status_ff[i-1];
         end
      end
   end

   // Merge stage: case selection and numerators.
   logic signed [33:0] d_w, den_w, s_w, ydev_w;
   logic signed [33:0] iq_w;
   logic front_w, plane_w;
   logic signed [79:0] nx_w, ny_w, nz_w;
   logic signed [31:0] mq_w;
   meta_type m_in;
   meta_type m_ff [NW+2];
   logic signed [79:0] nx_ff, ny_ff, nz_ff;
   logic [33:0] den_ff;
   logic signed [79:0] qx, qy, qz;

   always_comb begin
      front_w = fix[0] > fix[2];
      plane_w = fix[0] == fix[2];
      d_w = front_w ? 34'(fix[0]) - 34'(fix[2]) : 34'(fix[2]) - 34'(fix[0]);
      iq_w = $signed({10'd0, ipd_ff, 16'd0});
      den_w = front_w ? iq_w - d_w : iq_w + d_w;
      s_w = 34'(fix[1]) + 34'(fix[3]);
      mq_w = $signed({4'd0, height_ff, 16'd0});
      ydev_w = s_w - 34'({mq_w, 1'b0});
      nx_w = 80'((front_w ? (80'(fix[0]) * 2 - 80'(d_w)) : (80'(fix[0]) * 2 + 80'(d_w)))
             * $signed({1'b0, ipd_ff})) <<< 15;
      ny_w = 80'(80'(ydev_w) * $signed({1'b0, ipd_ff})) <<< 15;
      nz_w = 80'($signed({1'b0, ipd_ff}) * $signed({1'b0, plane_ff})) <<< 32;
      m_in.valid = c_valid_ff[2];
      m_in.status = c_status_ff[2];
      m_in.plane = plane_w;
      m_in.px = fix[0];
      m_in.py = 32'(s_w >>> 1) + 32'(s_w[33] & s_w[0]);
      m_in.pz = $signed({4'd0, plane_ff, 16'd0});
      m_in.sat = !plane_w && den_w <= 0;
      m_in.mq = mq_w;
      if (m_in.sat) begin
         m_in.pz = QMax;
         m_in.px = (nx_w >= 0) ? QMax : QMin;
         m_in.py = (ydev_w == 0) ? mq_w : ((ydev_w > 0) ? QMax : QMin);
      end
      if (c_status_ff[2] != StatusOk) begin
         m_in.sat = 1'b0;
         m_in.plane = 1'b1;
         m_in.px = '0;
         m_in.py = '0;
         m_in.pz = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW + 2; i++) begin
            m_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         m_ff[0] <= m_in;
         for (int i = 1; i < NW + 2; i++) begin
            m_ff[i] <= m_ff[i-1];
         end
         nx_ff <= nx_w;
         ny_ff <= ny_w;
         nz_ff <= nz_w;
         den_ff <= (den_w <= 0) ? 34'd1 : 34'(den_w);
      end
   end

   bgpr_divider #(.NW(NW), .DW(34)) u_dx (.clock, .enable(adv), .num(nx_ff),
      .den(den_ff), .quo(qx));
   bgpr_divider #(.NW(NW), .DW(34)) u_dy (.clock, .enable(adv), .num(ny_ff),
      .den(den_ff), .quo(qy));
   bgpr_divider #(.NW(NW), .DW(34)) u_dz (.clock, .enable(adv), .num(nz_ff),
      .den(den_ff), .quo(qz));

   meta_type mo;
   assign mo = m_ff[NW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= mo.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         if (mo.status != StatusOk) begin
            out_status_ff <= mo.status;
         end else begin
            out_status_ff <= mo.sat ? StatusSat : StatusOk;
         end
         if (mo.plane || mo.sat) begin
            out_x_ff <= mo.px;
            out_y_ff <= mo.py;
            out_z_ff <= mo.pz;
         end else begin
            out_x_ff <= sat32(96'(qx));
            out_y_ff <= sat32(96'(qy) + 96'(mo.mq));
            out_z_ff <= sat32(96'(qz));
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_gaze_x = out_x_ff;
   assign rsp_gaze_y = out_y_ff;
   assign rsp_gaze_z = out_z_ff;
endmodule
`default_nettype wire

### hw/rtl/bgpr_lane.sv
`default_nettype none
// One polynomial lane: registered pupil products, then registered term products, then registered sum and saturation.
module bgpr_lane
   import bgpr_pkg::*;
#(
   parameter int NUM_TERMS = NumTermsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [11:0]          px,
   input  wire logic [11:0]          py,
   input  wire logic signed [31:0]   coeff [NUM_TERMS],
   output logic signed [31:0]        fix
);
   logic [23:0] xx_ff, yy_ff, xy_ff;
   logic [11:0] x_ff, y_ff;
   logic signed [31:0] c_ff [NUM_TERMS];
   logic signed [63:0] prod_ff [NUM_TERMS];
   logic signed [31:0] fix_ff;
   logic signed [63:0] sum_in;
   logic [24:0] term [NUM_TERMS];

   always_comb begin
      for (int k = 0; k < NUM_TERMS; k++) begin
         case (k)
            0: term[k] = 25'd1;
            1: term[k] = {13'd0, x_ff};
            2: term[k] = {13'd0, y_ff};
            3: term[k] = {1'b0, xx_ff};
            4: term[k] = {1'b0, yy_ff};
            default: term[k] = {1'b0, xy_ff};
         endcase
      end
      sum_in = '0;
      for (int k = 0; k < NUM_TERMS; k++) begin
         sum_in = sum_in + prod_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xx_ff <= px * px;
         yy_ff <= py * py;
         xy_ff <= px * py;
         x_ff <= px;
         y_ff <= py;
         c_ff <= coeff;
         for (int k = 0; k < NUM_TERMS; k++) begin
            prod_ff[k] <= 64'(c_ff[k] * $signed(term[k]));
         end
         fix_ff <= sat32(96'(sum_in));
      end
   end
   assign fix = fix_ff;
endmodule
`default_nettype wire

### hw/rtl/bgpr_divider.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
module bgpr_divider
   import bgpr_pkg::*;
#(
   parameter int NW = 80,
   parameter int DW = 34
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire logic signed [NW-1:0] num,
   input  wire logic [DW-1:0]       den,
   output logic signed [NW-1:0]     quo
);
   logic [NW-1:0] n_ff [NW+1];
   logic [DW-1:0] d_ff [NW+1];
   logic [DW:0]   r_ff [NW+1];
   logic          s_ff [NW+1];
   logic [NW-1:0] mag;
   logic [DW+1:0] t [NW];

   assign mag = num[NW-1] ? NW'(-num) : NW'(num);

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         t[i] = {r_ff[i], n_ff[i][NW-1]} - {2'b0, d_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff[0] <= mag;
         d_ff[0] <= den;
         r_ff[0] <= '0;
         s_ff[0] <= num[NW-1];
         for (int i = 0; i < NW; i++) begin
            d_ff[i+1] <= d_ff[i];
            s_ff[i+1] <= s_ff[i];
            if (!t[i][DW+1]) begin
               r_ff[i+1] <= t[i][DW:0];
               n_ff[i+1] <= {n_ff[i][NW-2:0], 1'b1};
            end else begin
               r_ff[i+1] <= {r_ff[i][DW-1:0], n_ff[i][NW-1]};
               n_ff[i+1] <= {n_ff[i][NW-2:0], 1'b0};
            end
         end
      end
   end
   assign quo = s_ff[NW] ? NW'(-$signed(n_ff[NW])) : $signed(n_ff[NW]);
endmodule
`default_nettype wire

### tb/tb_binocular_gaze_point_of_regard_core.sv
`default_nettype none
module tb_binocular_gaze_point_of_regard_core;
   import bgpr_pkg::*;

   typedef struct {
      logic               command;
      logic [4:0]         coeff_index;
      logic signed [31:0] coeff_value;
      logic [11:0]        rx, ry, lx, ly;
   } gaze_req_type;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] gx, gy, gz;
   } gaze_rsp_type;

   typedef struct {
      bit           is_csr;
      logic [1:0]   csr_idx;
      logic [31:0]  csr_val;
      gaze_req_type item;
      bit           typed;
      gaze_rsp_type want;
   } stim_row_type;

   localparam int TableDepth = 24;
   localparam int Settle = 100;
   localparam longint QHi = 64'sd2147483647;
   localparam longint QLo = -64'sd2147483648;

   logic clock, reset;
   logic req_valid, req_ready, req_command;
   logic [4:0] req_coeff_index;
   logic signed [31:0] req_coeff_value;
   logic [11:0] req_right_pupil_x, req_right_pupil_y, req_left_pupil_x, req_left_pupil_y;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_gaze_x, rsp_gaze_y, rsp_gaze_z;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   binocular_gaze_point_of_regard_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_coeff_index(req_coeff_index), .req_coeff_value(req_coeff_value),
      .req_right_pupil_x(req_right_pupil_x), .req_right_pupil_y(req_right_pupil_y),
      .req_left_pupil_x(req_left_pupil_x), .req_left_pupil_y(req_left_pupil_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_gaze_x(rsp_gaze_x), .rsp_gaze_y(rsp_gaze_y), .rsp_gaze_z(rsp_gaze_z),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   logic signed [31:0] coeff_tab [TableDepth];
   longint ipd_mm, plane_mm, height_mm;
   bit maps_on;
   gaze_rsp_type gaze_q[$];
   int errors = 0;
   int burst_left = 0;
   bit hold_off_req = 0;
   stim_row_type rows[$];

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic longint sat_q(longint v);
      if (v > QHi) return QHi;
      if (v < QLo) return QLo;
      return v;
   endfunction

   function automatic longint fixation(int base, longint px, longint py);
      longint t[6];
      longint acc;
      t[0] = 1; t[1] = px; t[2] = py;
      t[3] = px * px; t[4] = py * py; t[5] = px * py;
      acc = 0;
      for (int k = 0; k < 6; k++) acc += longint'(coeff_tab[base + k]) * t[k];
      return sat_q(acc);
   endfunction

   function automatic gaze_rsp_type predict_gaze(gaze_req_type r);
      gaze_rsp_type o;
      longint frx, fry, flx, fly, mq, s, ydev, d, den, numx;
      bit front;
      o = '{StatusOk, 0, 0, 0};
      if (r.command == CmdLoad) begin
         if (r.coeff_index < TableDepth) coeff_tab[r.coeff_index] = r.coeff_value;
         o.status = StatusLoaded;
      end else if (!maps_on) begin
         o.status = StatusUncal;
      end else begin
         frx = fixation(0, r.rx, r.ry);
         fry = fixation(6, r.rx, r.ry);
         flx = fixation(12, r.lx, r.ly);
         fly = fixation(18, r.lx, r.ly);
         mq = height_mm * 65536;
         s = fry + fly;
         ydev = s - 2 * mq;
         if (frx == flx) begin
            o.gx = frx;
            o.gy = s / 2;
            o.gz = plane_mm * 65536;
         end else begin
            front = frx > flx;
            d = front ? frx - flx : flx - frx;
            den = front ? ipd_mm * 65536 - d : ipd_mm * 65536 + d;
            numx = front ? 2 * ipd_mm * frx - ipd_mm * d : 2 * ipd_mm * frx + ipd_mm * d;
            if (den <= 0) begin
               o.status = StatusSat;
               o.gz = QMax;
               o.gx = numx >= 0 ? QMax : QMin;
               o.gy = ydev == 0 ? mq : (ydev > 0 ? QMax : QMin);
            end else begin
               o.gz = sat_q((ipd_mm * plane_mm * 64'sd4294967296) / den);
               o.gx = sat_q((numx * 32768) / den);
               o.gy = sat_q((ydev * ipd_mm * 32768) / den + mq);
            end
         end
      end
      return o;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      gaze_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gaze_q.size() == 0) begin
            flag_mismatch("result with no item outstanding");
         end else begin
            e = gaze_q.pop_front();
            if (rsp_status !== e.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_status, e.status));
            if (rsp_gaze_x !== e.gx)
               flag_mismatch($sformatf("gaze_x %0d, want %0d", rsp_gaze_x, e.gx));
            if (rsp_gaze_y !== e.gy)
               flag_mismatch($sformatf("gaze_y %0d, want %0d", rsp_gaze_y, e.gy));
            if (rsp_gaze_z !== e.gz)
               flag_mismatch($sformatf("gaze_z %0d, want %0d", rsp_gaze_z, e.gz));
         end
      end
   end

   // The receiver switches among four stall patterns at random and holds off at length once.
   initial begin
      int mode;
      int cyc;
      rsp_ready = 1'b0;
      cyc = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_off_req) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_off_req = 0;
         end
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            2: rsp_ready = ($urandom_range(0, 3) == 0);
            default: rsp_ready = (cyc % 8) < 5;
         endcase
      end
   end

   task automatic send_item(gaze_req_type it, bit typed, gaze_rsp_type want);
      gaze_rsp_type p;
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid = 1'b1;
      req_command = it.command;
      req_coeff_index = it.coeff_index;
      req_coeff_value = it.coeff_value;
      req_right_pupil_x = it.rx;
      req_right_pupil_y = it.ry;
      req_left_pupil_x = it.lx;
      req_left_pupil_y = it.ly;
      do @(posedge clock); while (!req_ready);
      p = predict_gaze(it);
      if (typed) p = want;
      gaze_q.insert(gaze_q.size(), p);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (gaze_q.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrIpd: ipd_mm = val[7:0];
         CsrPlane: plane_mm = val[11:0];
         CsrHeight: height_mm = val[11:0];
         default: maps_on = val[0];
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(int ipd, int plane, int height, bit rdy);
      settle();
      write_csr(CsrIpd, ($urandom() & 32'hffffff00) | ipd);
      write_csr(CsrPlane, ($urandom() & 32'hfffff000) | plane);
      write_csr(CsrHeight, ($urandom() & 32'hfffff000) | height);
      write_csr(CsrReady, ($urandom() & 32'hfffffffe) | rdy);
   endtask

   function automatic gaze_req_type load_req(int idx, logic [31:0] val);
      return '{CmdLoad, idx[4:0], val, 12'($urandom), 12'($urandom), 12'($urandom),
               12'($urandom)};
   endfunction

   function automatic gaze_req_type comp_req(int rx, int ry, int lx, int ly);
      return '{CmdCompute, 5'($urandom), $urandom, rx[11:0], ry[11:0], lx[11:0], ly[11:0]};
   endfunction

   function automatic logic [31:0] unit_coeff(int idx);
      int axis, term;
      axis = (idx / 6) % 2;
      term = idx % 6;
      return ((axis == 0 && term == 1) || (axis == 1 && term == 2)) ? 32'h10000 : 32'h0;
   endfunction

   function automatic logic [31:0] rand_coeff(int idx);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return 32'h0;
         default: return unit_coeff(idx) + $urandom_range(0, 8191) - 4096;
      endcase
   endfunction

   function automatic gaze_req_type rand_compute();
      int rx, ry;
      rx = $urandom_range(0, 4095);
      ry = $urandom_range(0, 4095);
      case ($urandom_range(0, 3))
         0: return comp_req(rx, ry, rx, ry);
         1: return comp_req(rx, ry, rx + $urandom_range(0, 300) - 150,
                            ry + $urandom_range(0, 20) - 10);
         default: return comp_req(rx, ry, $urandom_range(0, 4095), $urandom_range(0, 4095));
      endcase
   endfunction

   task automatic add_item_row(gaze_req_type it, bit typed, gaze_rsp_type want);
      stim_row_type r;
      r = '{0, CsrIpd, 0, it, typed, want};
      rows.insert(rows.size(), r);
   endtask

   task automatic add_csr_row(logic [1:0] idx, logic [31:0] val);
      stim_row_type r;
      r = '{1, idx, val, comp_req(0, 0, 0, 0), 0, '{StatusOk, 0, 0, 0}};
      rows.insert(rows.size(), r);
   endtask

   initial begin
      int ipds[7];
      int planes[7];
      int heights[7];
      bit readies[7];
      gaze_rsp_type none;
      gaze_req_type it;
      int sent;

      ipds = '{64, 255, 1, 0, 200, 17, 128};
      planes = '{400, 4095, 1, 2048, 100, 777, 3000};
      heights = '{410, 4095, 0, 0, 4095, 1234, 50};
      readies = '{1, 1, 1, 1, 0, 1, 1};
      none = '{StatusOk, 0, 0, 0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CmdLoad;
      req_coeff_index = '0;
      req_coeff_value = '0;
      req_right_pupil_x = '0;
      req_right_pupil_y = '0;
      req_left_pupil_x = '0;
      req_left_pupil_y = '0;
      csr_valid = 1'b0;
      csr_index = CsrIpd;
      csr_data = '0;
      ipd_mm = IpdReset;
      plane_mm = PlaneReset;
      height_mm = HeightReset;
      maps_on = 1'b0;
      for (int i = 0; i < TableDepth; i++) coeff_tab[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_item_row(comp_req(4095, 0, 0, 4095), 1, '{StatusUncal, 0, 0, 0});
      for (int i = 0; i < TableDepth; i++)
         add_item_row(load_req(i, unit_coeff(i)), 1, '{StatusLoaded, 0, 0, 0});
      add_item_row(load_req(31, 32'h7fffffff), 1, '{StatusLoaded, 0, 0, 0});
      add_item_row(load_req(24, 32'h80000000), 1, '{StatusLoaded, 0, 0, 0});
      add_csr_row(CsrReady, 1);
      add_item_row(comp_req(100, 200, 100, 200), 0, none);
      add_item_row(comp_req(110, 200, 100, 300), 0, none);
      add_item_row(comp_req(100, 200, 110, 100), 0, none);
      add_item_row(comp_req(164, 300, 100, 100), 0, none);
      add_item_row(comp_req(4095, 4095, 0, 0), 0, none);
      add_item_row(comp_req(0, 0, 4095, 4095), 0, none);
      add_csr_row(CsrIpd, 0);
      add_item_row(comp_req(0, 9, 4095, 7), 0, none);

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            settle();
            write_csr(rows[i].csr_idx, rows[i].csr_val);
         end else begin
            send_item(rows[i].item, rows[i].typed, rows[i].want);
         end
      end

      sent = 0;
      for (int ph = 0; ph < 7; ph++) begin
         set_geometry(ipds[ph], planes[ph], heights[ph], readies[ph]);
         if ($urandom_range(0, 1))
            for (int i = 0; i < TableDepth; i++)
               send_item(load_req(i, rand_coeff(i)), 0, none);
         for (int n = 0; n < 140; n++) begin
            if ($urandom_range(0, 99) < 15)
               it = load_req($urandom_range(0, 31), rand_coeff($urandom_range(0, 23)));
            else
               it = rand_compute();
            send_item(it, 0, none);
            sent++;
            if (sent == 300) hold_off_req = 1;
         end
      end

      settle();
      if (errors == 0) begin
         $display("tb_binocular_gaze_point_of_regard_core: done, clean");
      end else begin
         $display("tb_binocular_gaze_point_of_regard_core: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_binocular_gaze_point_of_regard_core: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
